FILE: rtl/core/lps_pkg.sv
// lps_pkg: shared types and constants for the led pattern sequencer
// no dependencies; used by lps_in_if, lps_cfg_if and the top level

package lps_pkg;

  localparam int unsigned SLOT_W  = 16;
  localparam int unsigned PAT_W   = 32;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned SLOTS_W = 17;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_MODE    = 3'd1,
    REQ_PATTERN = 3'd2,
    REQ_COUNT   = 3'd3,
    REQ_BLINK   = 3'd4,
    REQ_PULSE   = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    MODE_TOGGLE = 3'd0,
    MODE_OFF    = 3'd1,
    MODE_ON     = 3'd2,
    MODE_BLINK  = 3'd3,
    MODE_SLOW   = 3'd4,
    MODE_FAST   = 3'd5,
    MODE_FLASH  = 3'd6,
    MODE_NONE   = 3'd7
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_HIGH  = 1'b1;

  localparam logic [PAT_W-1:0] PAT_OFF   = 32'h0000_0000;
  localparam logic [PAT_W-1:0] PAT_ON    = 32'hffff_ffff;
  localparam logic [PAT_W-1:0] PAT_BLINK = 32'hf0f0_f0f0;
  localparam logic [PAT_W-1:0] PAT_SLOW  = 32'hffff_0000;
  localparam logic [PAT_W-1:0] PAT_FAST  = 32'haaaa_aaaa;
  localparam logic [PAT_W-1:0] PAT_FLASH = 32'h8000_0000;

  localparam logic [SLOT_W-1:0] SLOT_TICKS_RST = 16'd100;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [2:0]              mode;
    logic [PAT_W-1:0]        pattern_word;
    logic signed [CNT_W-1:0] count_value;
    logic [SLOT_W-1:0]       pulse_ticks;
  } req_t;

endpackage

FILE: rtl/core/lps_in_if.sv
// lps_in_if: request channel of the led pattern sequencer
// depends on lps_pkg for field widths

interface lps_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        req_type;
  logic [2:0]                        mode;
  logic [lps_pkg::PAT_W-1:0]         pattern_word;
  logic signed [lps_pkg::CNT_W-1:0]  count_value;
  logic [lps_pkg::SLOT_W-1:0]        pulse_ticks;

  modport source (output valid, output req_type, output mode, output pattern_word,
                  output count_value, output pulse_ticks, input ready);
  modport sink (input valid, input req_type, input mode, input pattern_word,
                input count_value, input pulse_ticks, output ready);
endinterface

FILE: rtl/core/lps_out_if.sv
// lps_out_if: result channel of the led pattern sequencer
// no dependencies

interface lps_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic led_lit;
  logic pulse_active;

  modport source (output valid, output pin_level, output led_lit, output pulse_active,
                  input ready);
  modport sink (input valid, input pin_level, input led_lit, input pulse_active,
                output ready);
endinterface

FILE: rtl/core/lps_cfg_if.sv
// lps_cfg_if: register write channel of the led pattern sequencer
// depends on lps_pkg for index and data widths

interface lps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lps_pkg::CFG_IDX_W-1:0]     index;
  logic [lps_pkg::SLOT_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/led_pattern_sequencer_unit.sv
// led_pattern_sequencer_unit: led pattern sequencer, top level
// depends on lps_pkg, lps_in_if, lps_out_if, lps_cfg_if
//
//   channel  dir  beat contents
//   in_bus   in   req_type, mode, pattern_word, count_value, pulse_ticks
//   out_bus  out  pin_level, led_lit, pulse_active (one beat per request)
//   cfg_bus  in   index (0 slot_ticks, 1 idle_high), data
//
// one request per clock while the result is not stalled; a request is
// registered on entry, then updates the sequencer state and loads the
// result register once the result register is free or being taken.
// rst_n is synchronous active low and restores the register defaults.
// a stalled result holds the input register; cfg is always ready.

module led_pattern_sequencer_unit (
  input  logic      clk,
  input  logic      rst_n,
  lps_in_if.sink    in_bus,
  lps_out_if.source out_bus,
  lps_cfg_if.sink   cfg_bus
);

  logic                         in_valid_r;
  lps_pkg::req_t                in_req_r;
  logic                         advance;

  logic [lps_pkg::SLOT_W-1:0]   slot_ticks_r;
  logic                         idle_high_r;

  logic [lps_pkg::PAT_W-1:0]    pattern_r, pattern_nxt;
  logic [lps_pkg::PAT_W-1:0]    bit_sel_r, bit_sel_nxt;
  logic [lps_pkg::SLOTS_W-1:0]  slots_left_r, slots_left_nxt;
  logic                         led_on_r, led_on_nxt;
  logic                         pulse_on_r, pulse_on_nxt;
  logic                         armed_r, armed_nxt;
  logic [lps_pkg::SLOT_W-1:0]   wait_r, wait_nxt;

  logic                         out_valid_r;
  logic                         pin_r, lit_r, pulse_out_r;

  logic [lps_pkg::SLOTS_W-1:0]  slots_dec;
  logic [lps_pkg::PAT_W-1:0]    bit_sel_run;
  logic [lps_pkg::PAT_W-1:0]    mode_pat;
  logic                         mode_sets_pat;

  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid        = out_valid_r;
  assign out_bus.pin_level    = pin_r;
  assign out_bus.led_lit      = lit_r;
  assign out_bus.pulse_active = pulse_out_r;

  assign slots_dec   = slots_left_r - 17'd1;
  assign bit_sel_run = (bit_sel_r == '0) ? lps_pkg::PAT_FLASH : bit_sel_r;

  // pattern chosen by the blinking modes; mode none keeps the current one
  always_comb begin
    mode_pat      = pattern_r;
    mode_sets_pat = 1'b1;
    case (in_req_r.mode)
      lps_pkg::MODE_BLINK: mode_pat = lps_pkg::PAT_BLINK;
      lps_pkg::MODE_SLOW:  mode_pat = lps_pkg::PAT_SLOW;
      lps_pkg::MODE_FAST:  mode_pat = lps_pkg::PAT_FAST;
      lps_pkg::MODE_FLASH: mode_pat = lps_pkg::PAT_FLASH;
      lps_pkg::MODE_NONE:  mode_pat = pattern_r;
      default:             mode_sets_pat = 1'b0;
    endcase
  end

  always_comb begin
    pattern_nxt    = pattern_r;
    bit_sel_nxt    = bit_sel_r;
    slots_left_nxt = slots_left_r;
    led_on_nxt     = led_on_r;
    pulse_on_nxt   = pulse_on_r;
    armed_nxt      = armed_r;
    wait_nxt       = wait_r;
    unique case (in_req_r.req_type)
      lps_pkg::REQ_TICK: begin
        if (armed_r) begin
          if (wait_r <= 16'd1) begin
            armed_nxt = 1'b0;
            if (pulse_on_r) begin
              // pulse ends: led off, pattern restarts one slot later
              led_on_nxt   = 1'b0;
              pulse_on_nxt = 1'b0;
              bit_sel_nxt  = '0;
              armed_nxt    = 1'b1;
              wait_nxt     = slot_ticks_r;
            end else if (pattern_r != lps_pkg::PAT_OFF && pattern_r != lps_pkg::PAT_ON) begin
              bit_sel_nxt = bit_sel_run;
              if (!slots_left_r[lps_pkg::SLOTS_W-1] && slots_dec[lps_pkg::SLOTS_W-1]) begin
                // count ran out
                slots_left_nxt = slots_dec;
                led_on_nxt     = 1'b0;
              end else begin
                if (!slots_left_r[lps_pkg::SLOTS_W-1]) begin
                  slots_left_nxt = slots_dec;
                end
                led_on_nxt  = |(pattern_r & bit_sel_run);
                bit_sel_nxt = bit_sel_run >> 1;
                armed_nxt   = 1'b1;
                wait_nxt    = slot_ticks_r;
              end
            end
          end else begin
            wait_nxt = wait_r - 16'd1;
          end
        end
      end
      lps_pkg::REQ_MODE: begin
        case (in_req_r.mode)
          lps_pkg::MODE_TOGGLE: begin
            if (pattern_r == lps_pkg::PAT_OFF) begin
              pattern_nxt = lps_pkg::PAT_ON;
              led_on_nxt  = 1'b1;
            end else if (pattern_r == lps_pkg::PAT_ON) begin
              pattern_nxt = lps_pkg::PAT_OFF;
              if (!pulse_on_r) begin
                led_on_nxt = 1'b0;
              end
            end
          end
          lps_pkg::MODE_OFF: begin
            pattern_nxt = lps_pkg::PAT_OFF;
            if (!pulse_on_r) begin
              led_on_nxt = 1'b0;
            end
          end
          lps_pkg::MODE_ON: begin
            pattern_nxt = lps_pkg::PAT_ON;
            if (!pulse_on_r) begin
              led_on_nxt = 1'b1;
            end
          end
          default: begin
            if (mode_sets_pat && pattern_r != mode_pat) begin
              pattern_nxt = mode_pat;
              bit_sel_nxt = '0;
            end
            slots_left_nxt = '1;
            armed_nxt      = 1'b1;
            wait_nxt       = '0;
          end
        endcase
      end
      lps_pkg::REQ_PATTERN: begin
        pattern_nxt = in_req_r.pattern_word;
        bit_sel_nxt = '0;
        armed_nxt   = 1'b1;
        wait_nxt    = '0;
      end
      lps_pkg::REQ_COUNT: begin
        slots_left_nxt = {{(lps_pkg::SLOTS_W-lps_pkg::CNT_W){in_req_r.count_value[lps_pkg::CNT_W-1]}},
                          in_req_r.count_value};
      end
      lps_pkg::REQ_BLINK: begin
        pattern_nxt    = lps_pkg::PAT_BLINK;
        bit_sel_nxt    = '0;
        slots_left_nxt = {in_req_r.count_value[lps_pkg::CNT_W-1], in_req_r.count_value, 3'b000};
        armed_nxt      = 1'b1;
        wait_nxt       = '0;
      end
      lps_pkg::REQ_PULSE: begin
        led_on_nxt   = 1'b1;
        pulse_on_nxt = 1'b1;
        armed_nxt    = 1'b1;
        wait_nxt     = in_req_r.pulse_ticks;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_ticks_r <= lps_pkg::SLOT_TICKS_RST;
      idle_high_r  <= 1'b0;
      pattern_r    <= '0;
      bit_sel_r    <= '0;
      slots_left_r <= '0;
      led_on_r     <= 1'b0;
      pulse_on_r   <= 1'b0;
      armed_r      <= 1'b0;
      wait_r       <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_bus.valid) begin
        if (cfg_bus.index == lps_pkg::CFG_SLOT_TICKS) begin
          slot_ticks_r <= cfg_bus.data;
        end else begin
          idle_high_r <= cfg_bus.data[0];
        end
      end
      if (advance) begin
        pattern_r    <= pattern_nxt;
        bit_sel_r    <= bit_sel_nxt;
        slots_left_r <= slots_left_nxt;
        led_on_r     <= led_on_nxt;
        pulse_on_r   <= pulse_on_nxt;
        armed_r      <= armed_nxt;
        wait_r       <= wait_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_req_r.req_type     <= in_bus.req_type;
      in_req_r.mode         <= in_bus.mode;
      in_req_r.pattern_word <= in_bus.pattern_word;
      in_req_r.count_value  <= in_bus.count_value;
      in_req_r.pulse_ticks  <= in_bus.pulse_ticks;
    end
    if (advance) begin
      pin_r       <= led_on_nxt ^ idle_high_r;
      lit_r       <= led_on_nxt;
      pulse_out_r <= pulse_on_nxt;
    end
  end

endmodule
